// ===== hw/rtl/tjq_pkg.sv =====
// Shared types and codes for the timed job queue.
package tjq_pkg;

	typedef enum logic [1:0] {
		MODE_ADD  = 2'd0,
		MODE_DEL  = 2'd1,
		MODE_TICK = 2'd2,
		MODE_PROC = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_NONE_DUE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ID_ZERO   = 2'd0,
		ID_NEW    = 2'd1,
		ID_TARGET = 2'd2,
		ID_PEND   = 2'd3
	} id_src_t;

	typedef struct packed {
		logic [63:0] due;
		logic [31:0] id;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic    take;
		logic    add_id;
		logic    tick;
		logic    idx_load_count;
		logic    scan_start;
		logic    idx_inc;
		logic    idx_dec;
		logic    rd;
		logic    rd_prev;
		logic    wr;
		logic    wr_prev;
		logic    wr_new;
		logic    found_set;
		logic    count_inc;
		logic    count_dec;
		logic    pop;
		logic    pend_load;
		logic    emit;
		status_t emit_status;
		id_src_t emit_id;
		logic    emit_last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic idx_zero;
		logic idx_end;
		logic cmp_le;
		logic due_now;
		logic id_match;
		logic found;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/tjq_req_if.sv =====
// Request channel of the timed job queue.
interface tjq_req_if;
	logic             valid;
	logic             ready;
	tjq_pkg::mode_t   mode;
	logic [31:0]      wait_ticks;
	logic [31:0]      target_id;

	modport source (output valid, mode, wait_ticks, target_id, input ready);
	modport sink (input valid, mode, wait_ticks, target_id, output ready);
endinterface

// ===== hw/rtl/tjq_rsp_if.sv =====
// Response channel of the timed job queue.
interface tjq_rsp_if;
	logic             valid;
	logic             ready;
	tjq_pkg::status_t status;
	logic [31:0]      job_id;
	logic             last;

	modport source (output valid, status, job_id, last, input ready);
	modport sink (input valid, status, job_id, last, output ready);
endinterface

// ===== hw/rtl/timed_job_queue.sv =====
// Top level of the timed job queue: sorted timer queue of up to DEPTH jobs.
//
//   channel  direction  fields                          meaning
//   req      in         mode, wait_ticks, target_id     add, delete, tick, process
//   rsp      out        status, job_id, last            one or more per request
//
// One request at a time; jobs live in a single-port ring memory with a
// registered read, so every visited entry passes through a read and a check state.
// Tick and add to a full queue go straight to the response. Add walks the
// entries due later than the new job, until an earlier entry ends the walk.
// Delete walks every entry. Process walks the due jobs, until a job
// not yet due ends the walk.
// Reset clears the time, the id counter and the fill count; no clearing pass.
// A stalled response holds the controller; the next request is taken while
// the last response still waits in the output register.
module timed_job_queue #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	tjq_req_if.sink    req,
	tjq_rsp_if.source  rsp
);
	import tjq_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign req.ready = in_ready;

	tjq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_mode  (req.mode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tjq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.wait_ticks (req.wait_ticks),
		.target_id  (req.target_id),
		.cmd        (cmd),
		.sts        (sts),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.rsp_status (rsp.status),
		.rsp_job_id (rsp.job_id),
		.rsp_last   (rsp.last)
	);

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("response loaded while output register busy");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |-> !sts.full)
		else $error("insert into a full queue");

	a_prev_index: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.rd && cmd.rd_prev) || (cmd.wr && cmd.wr_prev)) |-> !sts.idx_zero)
		else $error("access before the queue head");

	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while previous request in progress");
`endif

endmodule

// ===== hw/rtl/tjq_dpath.sv =====
// Datapath of the timed job queue: ring memory, counters, compares, response register.
module tjq_dpath #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        wait_ticks,
	input  logic [31:0]        target_id,
	input  tjq_pkg::cmd_t      cmd,
	output tjq_pkg::sts_t      sts,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output tjq_pkg::status_t   rsp_status,
	output logic [31:0]        rsp_job_id,
	output logic               rsp_last
);
	import tjq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	entry_t         mem [DEPTH];
	entry_t         rd_q;
	entry_t         wr_data;
	logic [63:0]    now_q;
	logic [31:0]    next_id_q;
	logic [63:0]    new_due_q;
	logic [31:0]    new_id_q;
	logic [31:0]    target_q;
	logic [31:0]    pend_q;
	logic           pend_valid_q;
	logic           found_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  idx_m1;
	logic [AW-1:0]  head_q;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic           rsp_valid_q;
	status_t        rsp_status_q;
	logic [31:0]    rsp_id_q;
	logic           rsp_last_q;
	logic [31:0]    emit_id;
	logic           out_free;

	// Map a position in queue order to a slot of the ring
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH))
			sum = sum - SW'(DEPTH);
		return sum[AW-1:0];
	endfunction

	assign idx_m1  = idx_q - CW'(1);
	assign rd_addr = slot(head_q, cmd.rd_prev ? idx_m1 : idx_q);
	assign wr_addr = slot(head_q, cmd.wr_prev ? idx_m1 : idx_q);
	assign wr_data = cmd.wr_new ? entry_t'{due: new_due_q, id: new_id_q} : rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[wr_addr] <= wr_data;
		if (cmd.rd)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			new_due_q <= now_q + 64'(wait_ticks);
			new_id_q  <= next_id_q;
			target_q  <= target_id;
		end
		if (cmd.pend_load)
			pend_q <= rd_q.id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			next_id_q    <= '0;
			count_q      <= '0;
			head_q       <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.tick)
				now_q <= now_q + 64'd1;
			if (cmd.add_id)
				next_id_q <= next_id_q + 32'd1;

			if (cmd.idx_load_count)
				idx_q <= count_q;
			else if (cmd.scan_start)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + CW'(1);
			else if (cmd.idx_dec)
				idx_q <= idx_m1;

			if (cmd.scan_start) begin
				found_q      <= 1'b0;
				pend_valid_q <= 1'b0;
			end else begin
				if (cmd.found_set)
					found_q <= 1'b1;
				if (cmd.pend_load)
					pend_valid_q <= 1'b1;
			end

			// Drop the expired jobs by moving the head past them
			if (cmd.pop) begin
				head_q  <= slot(head_q, idx_q);
				count_q <= count_q - idx_q;
			end else if (cmd.count_inc)
				count_q <= count_q + CW'(1);
			else if (cmd.count_dec)
				count_q <= count_q - CW'(1);
		end
	end

	always_comb begin
		case (cmd.emit_id)
			ID_NEW:    emit_id = new_id_q;
			ID_TARGET: emit_id = target_q;
			ID_PEND:   emit_id = pend_q;
			default:   emit_id = '0;
		endcase
	end

	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.emit)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_status_q <= cmd.emit_status;
			rsp_id_q     <= emit_id;
			rsp_last_q   <= cmd.emit_last;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp_status = rsp_status_q;
	assign rsp_job_id = rsp_id_q;
	assign rsp_last   = rsp_last_q;

	assign sts.full       = count_q == CW'(DEPTH);
	assign sts.idx_zero   = idx_q == '0;
	assign sts.idx_end    = idx_q == count_q;
	assign sts.cmp_le     = rd_q.due <= new_due_q;
	assign sts.due_now    = rd_q.due <= now_q;
	assign sts.id_match   = rd_q.id == target_q;
	assign sts.found      = found_q;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

endmodule

// ===== hw/rtl/tjq_ctrl.sv =====
// Controller state machine of the timed job queue.
module tjq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tjq_pkg::mode_t    in_mode,
	output logic              in_ready,
	input  tjq_pkg::sts_t     sts,
	output tjq_pkg::cmd_t     cmd
);
	import tjq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_CHK,
		S_DEL_RD,
		S_DEL_CHK,
		S_PR_RD,
		S_PR_CHK,
		S_PR_END,
		S_RESP
	} state_t;

	state_t  state_q;
	status_t resp_status_q;
	id_src_t resp_id_q;

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			resp_status_q <= ST_OK;
			resp_id_q     <= ID_ZERO;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_mode)
							MODE_ADD: begin
								if (sts.full) begin
									resp_status_q <= ST_FULL;
									resp_id_q     <= ID_NEW;
									state_q       <= S_RESP;
								end else
									state_q <= S_ADD_RD;
							end
							MODE_DEL: state_q <= S_DEL_RD;
							MODE_TICK: begin
								resp_status_q <= ST_OK;
								resp_id_q     <= ID_ZERO;
								state_q       <= S_RESP;
							end
							MODE_PROC: state_q <= S_PR_RD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ADD_RD: begin
					if (sts.idx_zero) begin
						resp_status_q <= ST_OK;
						resp_id_q     <= ID_NEW;
						state_q       <= S_RESP;
					end else
						state_q <= S_ADD_CHK;
				end
				S_ADD_CHK: begin
					if (sts.cmp_le) begin
						resp_status_q <= ST_OK;
						resp_id_q     <= ID_NEW;
						state_q       <= S_RESP;
					end else
						state_q <= S_ADD_RD;
				end
				S_DEL_RD: begin
					if (sts.idx_end) begin
						resp_status_q <= sts.found ? ST_OK : ST_NOT_FOUND;
						resp_id_q     <= ID_TARGET;
						state_q       <= S_RESP;
					end else
						state_q <= S_DEL_CHK;
				end
				S_DEL_CHK: state_q <= S_DEL_RD;
				S_PR_RD: state_q <= sts.idx_end ? S_PR_END : S_PR_CHK;
				S_PR_CHK: begin
					if (!sts.due_now)
						state_q <= S_PR_END;
					else if (!sts.pend_valid || sts.out_free)
						state_q <= S_PR_RD;
				end
				S_PR_END: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				S_RESP: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					case (in_mode)
						MODE_ADD: begin
							cmd.add_id         = 1'b1;
							cmd.idx_load_count = 1'b1;
						end
						MODE_DEL:  cmd.scan_start = 1'b1;
						MODE_TICK: cmd.tick = 1'b1;
						MODE_PROC: cmd.scan_start = 1'b1;
						default: cmd.take = 1'b1;
					endcase
				end
			end
			// Walk back from the tail, shifting later jobs up by one
			S_ADD_RD: begin
				if (sts.idx_zero) begin
					cmd.wr        = 1'b1;
					cmd.wr_new    = 1'b1;
					cmd.count_inc = 1'b1;
				end else begin
					cmd.rd      = 1'b1;
					cmd.rd_prev = 1'b1;
				end
			end
			S_ADD_CHK: begin
				cmd.wr = 1'b1;
				if (sts.cmp_le) begin
					cmd.wr_new    = 1'b1;
					cmd.count_inc = 1'b1;
				end else
					cmd.idx_dec = 1'b1;
			end
			S_DEL_RD: begin
				if (sts.idx_end)
					cmd.count_dec = sts.found;
				else
					cmd.rd = 1'b1;
			end
			// Once matched, move each following entry down by one
			S_DEL_CHK: begin
				if (sts.found) begin
					cmd.wr      = 1'b1;
					cmd.wr_prev = 1'b1;
				end else
					cmd.found_set = sts.id_match;
				cmd.idx_inc = 1'b1;
			end
			S_PR_RD: cmd.rd = !sts.idx_end;
			// Hold one due job back until the next one tells whether it is the last
			S_PR_CHK: begin
				if (sts.due_now && (!sts.pend_valid || sts.out_free)) begin
					cmd.pend_load   = 1'b1;
					cmd.idx_inc     = 1'b1;
					cmd.emit        = sts.pend_valid;
					cmd.emit_status = ST_OK;
					cmd.emit_id     = ID_PEND;
				end
			end
			S_PR_END: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.pop         = 1'b1;
					cmd.emit_status = sts.pend_valid ? ST_OK : ST_NONE_DUE;
					cmd.emit_id     = sts.pend_valid ? ID_PEND : ID_ZERO;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = resp_status_q;
					cmd.emit_id     = resp_id_q;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule
